// ===== rtl/tmps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_pkg: shared types and constants
// Widths of the cell values and path sums, and the control structs that pass
// from the top level to the row queue and from the row queue to its cells.
// ----------------------------------------------------------------------------
package tmps_pkg;

  localparam int CELL_W = 8;
  localparam int SUM_W  = 16;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Command from the top level to the row queue.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_cmd_t;

  // Per-entry control from the row queue to one of its cells.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== rtl/tmps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_cell: one entry of the row queue
// Holds one path sum. It either keeps it, takes its upstream neighbor's sum
// when the queue advances, or loads the newly computed sum.
// ----------------------------------------------------------------------------
module tmps_cell
  import tmps_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  sum_t      neighbor_sum,
  input  sum_t      push_sum,
  output sum_t      sum_q
);

  sum_t data_r;
  sum_t data_nxt;

  always_comb begin
    if (ctl.load) begin
      data_nxt = push_sum;
    end else if (ctl.shift) begin
      data_nxt = neighbor_sum;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign sum_q = data_r;

endmodule

// ===== rtl/tmps_row_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_row_queue: chain of cells holding the previous row's path sums
// The previous row is consumed from the head in column order while the
// current row's sums are appended behind it, so a shifting queue replaces
// the addressed row buffer.
// ----------------------------------------------------------------------------
module tmps_row_queue
  import tmps_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  q_cmd_t cmd,
  input  sum_t   push_sum,
  output sum_t   head_sum
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  sum_t             cell_sum [DEPTH];

  always_comb begin
    if (cmd.clear) begin
      count_nxt = '0;
    end else begin
      count_nxt = count_r + CNT_W'(cmd.push) - CNT_W'(cmd.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    sum_t      neighbor;

    always_comb begin
      ctl.shift = cmd.pop;
      if (cmd.pop) begin
        ctl.load = cmd.push && (count_r == CNT_W'(i + 1));
      end else begin
        ctl.load = cmd.push && (count_r == CNT_W'(i));
      end
    end

    if (i == DEPTH - 1) begin : g_tail
      assign neighbor = push_sum;
    end else begin : g_body
      assign neighbor = cell_sum[i+1];
    end

    tmps_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .neighbor_sum (neighbor),
      .push_sum     (push_sum),
      .sum_q        (cell_sum[i])
    );
  end

  assign head_sum = cell_sum[0];

endmodule

// ===== rtl/triangle_max_path_sum.sv =====
`timescale 1ns / 1ps
// Latency: the result item is valid in the cycle after the last cell is accepted.
// Throughput: one cell item per clock cycle unless a result waits on a stalled
// receiver; the next triangle may start in the cycle after the previous last cell.
// Reset (rst_n low, synchronous) clears position counters, running best, error
// flag and queue fill; the stored sums need no clearing, so there is no sweep.
// ----------------------------------------------------------------------------
// triangle_max_path_sum: streaming maximum path sum of a number triangle
// Cells arrive in row-major order. The previous row's best path sums sit in a
// chain of cells that works as a queue: each interior cell item pops the sum
// above it from the head, each valid cell item pushes its own new sum at the
// tail, and one add, at most two compares and one queue step finish every cell.
// ----------------------------------------------------------------------------
module triangle_max_path_sum
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_cell_value,
  input  logic        in_row_end,
  input  logic        in_triangle_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_best_sum,
  output logic        out_shape_error
);

  // Position counters must hold MAX_ROWS itself, since both saturate there.
  localparam int IDX_W = $clog2(MAX_ROWS + 1);
  localparam logic [IDX_W-1:0] ROW_LIMIT = IDX_W'(MAX_ROWS);

  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  sum_t             left_r, left_nxt;
  sum_t             best_r, best_nxt;
  logic             err_r, err_nxt;

  logic             out_valid_r, out_valid_nxt;
  sum_t             out_sum_r, out_sum_nxt;
  logic             out_err_r, out_err_nxt;

  logic             accept;
  logic             last_cell;
  logic             bad_pos;
  logic             interior;
  logic             update;
  sum_t             head_sum;
  sum_t             parent;
  sum_t             new_sum;
  sum_t             best_upd;
  q_cmd_t           q_cmd;

  // A waiting result blocks the input only while the receiver stalls: the
  // output register is refilled in the same cycle that its old item is taken.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign last_cell = in_row_end || in_triangle_end;

  // A cell past the row's right edge, or after the last allowed row, is a
  // shape error and does not touch the sums.
  assign bad_pos  = (row_r >= ROW_LIMIT) || (col_r > row_r);
  assign update   = accept && !err_r && !bad_pos;

  // Columns left of the right edge have a parent directly above, which sits
  // at the queue head. The left parent is zero at the start of each row, so
  // the left-edge cell naturally takes only the parent above it.
  assign interior = col_r < row_r;

  always_comb begin
    if (interior) begin
      parent = (head_sum > left_r) ? head_sum : left_r;
    end else begin
      parent = left_r;
    end
    new_sum = parent + sum_t'(in_cell_value);

    if ((col_r == '0) || (new_sum > best_r)) begin
      best_upd = new_sum;
    end else begin
      best_upd = best_r;
    end
  end

  always_comb begin
    q_cmd.clear = accept && in_triangle_end;
    q_cmd.push  = update;
    q_cmd.pop   = update && interior;
  end

  tmps_row_queue #(
    .DEPTH (MAX_ROWS)
  ) u_row_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (q_cmd),
    .push_sum (new_sum),
    .head_sum (head_sum)
  );

  // Position, running best and error tracking.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    best_nxt = best_r;
    err_nxt  = err_r;

    if (accept && !err_r) begin
      if (bad_pos || (last_cell && (col_r != row_r))) begin
        err_nxt = 1'b1;
      end
    end

    if (update) begin
      left_nxt = head_sum;
      best_nxt = best_upd;
    end

    if (accept) begin
      priority if (in_triangle_end) begin
        col_nxt  = '0;
        row_nxt  = '0;
        left_nxt = '0;
        best_nxt = '0;
        err_nxt  = 1'b0;
      end else if (in_row_end) begin
        col_nxt  = '0;
        left_nxt = '0;
        if (row_r < ROW_LIMIT) begin
          row_nxt = row_r + IDX_W'(1);
        end
      end else if (col_r < ROW_LIMIT) begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  // Result register: one item per triangle, on its last cell.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept && in_triangle_end) begin
      out_valid_nxt = 1'b1;
      if (err_r || bad_pos || (col_r != row_r)) begin
        out_sum_nxt = '0;
        out_err_nxt = 1'b1;
      end else begin
        out_sum_nxt = best_upd;
        out_err_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      best_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      best_r      <= best_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_best_sum    = out_sum_r;
  assign out_shape_error = out_err_r;

endmodule
